// ----- design/mmc_pkg.sv -----
// Shared types and constants of the magnetometer min/max calibrator.
`timescale 1ns / 1ps
package mmc_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_CAL_COUNT    = 3'd0;
	localparam logic [2:0] CFG_BG_FRESH     = 3'd1;
	localparam logic [2:0] CFG_BG_REFINE    = 3'd2;
	localparam logic [2:0] CFG_RNG_FRESH    = 3'd3;
	localparam logic [2:0] CFG_RNG_REFINE   = 3'd4;
	localparam logic [2:0] CFG_SCALE_FLOOR  = 3'd5;
	localparam logic [2:0] CFG_BOUND_MARGIN = 3'd6;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int CNT_CFG_W = 10;
	localparam int RNG_CFG_W = 15;

	// Unsigned Q8.12 scale
	localparam int SCALE_W = 20;
	localparam int SCALE_FRAC = 12;
	localparam int SCALE_ONE = 4096;
	localparam int ROUND_HALF = 2048;

	// Reset value of tracking extremes and validation bounds
	localparam int RESET_BOUND = 16000;

	// Background round result codes
	localparam logic [1:0] BG_NONE = 2'd0;
	localparam logic [1:0] BG_UPDATED = 2'd1;
	localparam logic [1:0] BG_SHORT = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_FG_TRACK,
		ST_FG_CHK,
		ST_FG_SET,
		ST_SC_SUM,
		ST_SC_AX,
		ST_SC_WAIT,
		ST_BG_TRACK,
		ST_BG_CHK,
		ST_BG_REF,
		ST_BG_MID,
		ST_BG_END,
		ST_COR,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_OUT
	} st_t;

endpackage

// ----- design/mmc_sdiv.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mmc_sdiv #(
	parameter int NW = 30,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DW:0] rem_sh;
	logic [DW:0] diff;

	// Shift in the next numerator bit and try a subtract
	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
		diff = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ----- design/mmc_smul.sv -----
// Bit-serial shift-add multiplier, signed by unsigned, MSB of the multiplier first.
`timescale 1ns / 1ps
module mmc_smul #(
	parameter int AW = 17,
	parameter int BW = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [AW-1:0]    a,
	input  logic [BW-1:0]           b,
	output logic                    done,
	output logic signed [AW+BW-1:0] prod
);

	localparam int PW = AW + BW;
	localparam int CNTW = $clog2(BW + 1);

	logic signed [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic signed [PW-1:0] acc_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic signed [PW-1:0] acc_next;

	// Double the partial sum and add the multiplicand on a set bit
	always_comb begin
		acc_next = (acc_q <<< 1) + (b_q[BW-1] ? PW'(a_q) : PW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q <= {b_q[BW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- design/magnetometer_minmax_calibrator_core.sv -----
// Top level: min/max hard- and soft-iron calibration with serial arithmetic.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid in_ready func mag_x mag_y mag_z bg_due | into block
//  out     | out_valid out_ready corr_x corr_y corr_z        | out of block
//          | corrected out_of_range calibrating              |
//          | fg_finished bg_status                           |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | into block
//
// One word at a time. For a corrected sample the bit-serial multiplier runs
// once per axis; a sample that feeds the background round also passes
// ST_BG_CHK. A calibration end adds up to three divisions in the bit-serial
// divider. A start command passes through ST_START and then ST_OUT.
// Reset clears all calibration state at once; no clearing pass is needed.
// A result held in the output register stalls only the last step.
`timescale 1ns / 1ps
module magnetometer_minmax_calibrator_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic signed [SAMPLE_WIDTH-1:0]    mag_x,
	input  logic signed [SAMPLE_WIDTH-1:0]    mag_y,
	input  logic signed [SAMPLE_WIDTH-1:0]    mag_z,
	input  logic                              bg_due,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]    corr_x,
	output logic signed [SAMPLE_WIDTH-1:0]    corr_y,
	output logic signed [SAMPLE_WIDTH-1:0]    corr_z,
	output logic                              corrected,
	output logic                              out_of_range,
	output logic                              calibrating,
	output logic                              fg_finished,
	output logic [1:0]                        bg_status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int W = SAMPLE_WIDTH;
	localparam int MW = (W > 15) ? W : 15;
	localparam int CW = COUNT_WIDTH;
	localparam int CMPW = (CW > mmc_pkg::CNT_CFG_W) ? CW : mmc_pkg::CNT_CFG_W;
	localparam int EW = ((MW > 16) ? MW : 16) + 2;
	localparam int RW = (((MW + 1) > 16) ? (MW + 1) : 16) + 1;
	localparam int SW = W + 2;
	localparam int NW = W + 14;
	localparam int DW = W + 2;
	localparam int AW = W + 1;
	localparam int PW = AW + mmc_pkg::SCALE_W;
	localparam int VW = PW - mmc_pkg::SCALE_FRAC;
	localparam int SCW = mmc_pkg::SCALE_W;

	localparam logic signed [MW-1:0] BOUND_HI = MW'(mmc_pkg::RESET_BOUND);
	localparam logic signed [MW-1:0] BOUND_LO = MW'(-mmc_pkg::RESET_BOUND);
	localparam longint S_HI = (64'sd1 <<< (W - 1)) - 1;
	localparam logic signed [EW-1:0] E_HI = EW'(S_HI);
	localparam logic signed [EW-1:0] E_LO = EW'(-S_HI - 1);
	localparam logic signed [VW-1:0] V_HI = VW'(S_HI);
	localparam logic signed [VW-1:0] V_LO = VW'(-S_HI - 1);

	mmc_pkg::st_t state_q, state_d;

	// Configuration registers
	logic [mmc_pkg::CNT_CFG_W-1:0] cal_cnt_q, bg_fresh_q, bg_refine_q;
	logic [mmc_pkg::RNG_CFG_W-1:0] rng_fresh_q, rng_refine_q, sc_floor_q, margin_q;

	// Calibration state
	logic signed [W-1:0]  off_q [3];
	logic [SCW-1:0]       scale_q [3];
	logic signed [MW-1:0] vlo_q [3];
	logic signed [MW-1:0] vhi_q [3];
	logic signed [MW-1:0] fmin_q [3];
	logic signed [MW-1:0] fmax_q [3];
	logic signed [MW-1:0] bmin_q [3];
	logic signed [MW-1:0] bmax_q [3];
	logic fg_active_q, bg_started_q, has_stored_q;
	logic [CW-1:0] fg_cnt_q, bg_cnt_q;

	// Word in flight
	logic func_q, bg_due_q;
	logic signed [W-1:0] s_q [3];
	logic [1:0] ax_q;
	logic src_bg_q;
	logic [SW-1:0] sum_q;
	logic signed [W-1:0] corr_q [3];
	logic oor_q, fin_q, applied_q;
	logic [1:0] status_q;

	// Output register
	logic out_valid_q;
	logic signed [W-1:0] ox_q, oy_q, oz_q;
	logic ocorr_q, ooor_q, ocal_q, ofin_q;
	logic [1:0] ostat_q;

	// Arithmetic units
	logic div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;
	logic mul_start, mul_done;
	logic signed [AW-1:0] mul_a;
	logic signed [PW-1:0] mul_prod;

	logic in_take;
	logic fg_ge, bg_ge, rng_ok, applied, last_ax, d_gt;
	logic signed [MW-1:0] cur_min, cur_max;
	logic signed [MW:0] d, d0, d1, d2;
	logic [W-1:0] r_cur;
	logic [CW-1:0] fg_cnt_inc, bg_cnt_inc;
	logic [mmc_pkg::CNT_CFG_W-1:0] need;
	logic [mmc_pkg::RNG_CFG_W-1:0] floor_r;
	logic signed [RW-1:0] rx, ry, floor_ext, d_ext, sc_floor_ext;
	logic [SCW-1:0] q_sat;
	logic signed [PW-1:0] pr;
	logic signed [VW-1:0] v, vlo_ext, vhi_ext;

	assign cfg_ready = 1'b1;
	assign in_take = in_valid && in_ready;

	// Counter steps and compares
	always_comb begin
		fg_cnt_inc = (fg_cnt_q == '1) ? fg_cnt_q : fg_cnt_q + 1'b1;
		bg_cnt_inc = (bg_cnt_q == '1) ? bg_cnt_q : bg_cnt_q + 1'b1;
		fg_ge = CMPW'(fg_cnt_q) >= CMPW'(cal_cnt_q);
		need = has_stored_q ? bg_refine_q : bg_fresh_q;
		bg_ge = CMPW'(bg_cnt_q) >= CMPW'(need);
		floor_r = has_stored_q ? rng_refine_q : rng_fresh_q;
		rx = RW'(bmax_q[0]) - RW'(bmin_q[0]);
		ry = RW'(bmax_q[1]) - RW'(bmin_q[1]);
		floor_ext = RW'($signed({1'b0, floor_r}));
		rng_ok = (rx > floor_ext) && (ry > floor_ext);
		applied = (!fg_active_q && fg_ge) || (off_q[0] != '0);
		last_ax = (ax_q == 2'd2);
	end

	// Scale path: range of the current axis and divider operands
	always_comb begin
		cur_min = src_bg_q ? bmin_q[ax_q] : fmin_q[ax_q];
		cur_max = src_bg_q ? bmax_q[ax_q] : fmax_q[ax_q];
		d = (MW+1)'(cur_max) - (MW+1)'(cur_min);
		d0 = src_bg_q ? (MW+1)'(bmax_q[0]) - (MW+1)'(bmin_q[0])
			: (MW+1)'(fmax_q[0]) - (MW+1)'(fmin_q[0]);
		d1 = src_bg_q ? (MW+1)'(bmax_q[1]) - (MW+1)'(bmin_q[1])
			: (MW+1)'(fmax_q[1]) - (MW+1)'(fmin_q[1]);
		d2 = src_bg_q ? (MW+1)'(bmax_q[2]) - (MW+1)'(bmin_q[2])
			: (MW+1)'(fmax_q[2]) - (MW+1)'(fmin_q[2]);
		d_ext = RW'(d);
		sc_floor_ext = RW'($signed({1'b0, sc_floor_q}));
		d_gt = d_ext > sc_floor_ext;
		r_cur = d[W-1:0];
		div_den = DW'(r_cur) + (DW'(r_cur) << 1);
		div_num = (NW'(sum_q) << mmc_pkg::SCALE_FRAC) + NW'(div_den >> 1);
		q_sat = (|div_quo[NW-1:SCW]) ? '1 : div_quo[SCW-1:0];
	end

	// Correction path: round, bound check and saturation
	always_comb begin
		mul_a = AW'(s_q[ax_q]) - AW'(off_q[ax_q]);
		pr = mul_prod + PW'(mmc_pkg::ROUND_HALF);
		v = pr[PW-1:mmc_pkg::SCALE_FRAC];
		vlo_ext = VW'(vlo_q[ax_q]);
		vhi_ext = VW'(vhi_q[ax_q]);
	end

	mmc_sdiv #(.NW(NW), .DW(DW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	mmc_smul #(.AW(AW), .BW(SCW)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(scale_q[ax_q]),
		.done(mul_done),
		.prod(mul_prod)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit strobes
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		case (state_q)
			mmc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func) state_d = mmc_pkg::ST_START;
					else if (fg_active_q) state_d = mmc_pkg::ST_FG_TRACK;
					else state_d = mmc_pkg::ST_BG_TRACK;
				end
			end
			mmc_pkg::ST_START: state_d = mmc_pkg::ST_OUT;
			mmc_pkg::ST_FG_TRACK: state_d = mmc_pkg::ST_FG_CHK;
			mmc_pkg::ST_FG_CHK: begin
				state_d = fg_ge ? mmc_pkg::ST_FG_SET : mmc_pkg::ST_BG_TRACK;
			end
			mmc_pkg::ST_FG_SET: state_d = mmc_pkg::ST_SC_SUM;
			mmc_pkg::ST_SC_SUM: state_d = mmc_pkg::ST_SC_AX;
			mmc_pkg::ST_SC_AX: begin
				if (d_gt) begin
					div_start = 1'b1;
					state_d = mmc_pkg::ST_SC_WAIT;
				end else if (last_ax) begin
					state_d = src_bg_q ? mmc_pkg::ST_BG_END : mmc_pkg::ST_BG_TRACK;
				end
			end
			mmc_pkg::ST_SC_WAIT: begin
				if (div_done) begin
					if (last_ax)
						state_d = src_bg_q ? mmc_pkg::ST_BG_END : mmc_pkg::ST_BG_TRACK;
					else
						state_d = mmc_pkg::ST_SC_AX;
				end
			end
			mmc_pkg::ST_BG_TRACK: begin
				state_d = bg_due_q ? mmc_pkg::ST_BG_CHK : mmc_pkg::ST_COR;
			end
			mmc_pkg::ST_BG_CHK: begin
				if (!bg_ge) state_d = mmc_pkg::ST_COR;
				else if (!rng_ok) state_d = mmc_pkg::ST_BG_END;
				else if (has_stored_q) state_d = mmc_pkg::ST_BG_REF;
				else state_d = mmc_pkg::ST_BG_MID;
			end
			mmc_pkg::ST_BG_REF: state_d = mmc_pkg::ST_BG_END;
			mmc_pkg::ST_BG_MID: state_d = mmc_pkg::ST_SC_SUM;
			mmc_pkg::ST_BG_END: state_d = mmc_pkg::ST_COR;
			mmc_pkg::ST_COR: begin
				state_d = applied ? mmc_pkg::ST_MUL_GO : mmc_pkg::ST_OUT;
			end
			mmc_pkg::ST_MUL_GO: begin
				mul_start = 1'b1;
				state_d = mmc_pkg::ST_MUL_WAIT;
			end
			mmc_pkg::ST_MUL_WAIT: begin
				if (mul_done) state_d = last_ax ? mmc_pkg::ST_OUT : mmc_pkg::ST_MUL_GO;
			end
			mmc_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = mmc_pkg::ST_IDLE;
			end
			default: state_d = mmc_pkg::ST_IDLE;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q <= 10'd100;
			bg_fresh_q <= 10'd200;
			bg_refine_q <= 10'd500;
			rng_fresh_q <= 15'd320;
			rng_refine_q <= 15'd480;
			sc_floor_q <= 15'd160;
			margin_q <= 15'd800;
		end else if (cfg_valid) begin
			case (cfg_index)
				mmc_pkg::CFG_CAL_COUNT: cal_cnt_q <= cfg_data[mmc_pkg::CNT_CFG_W-1:0];
				mmc_pkg::CFG_BG_FRESH: bg_fresh_q <= cfg_data[mmc_pkg::CNT_CFG_W-1:0];
				mmc_pkg::CFG_BG_REFINE: bg_refine_q <= cfg_data[mmc_pkg::CNT_CFG_W-1:0];
				mmc_pkg::CFG_RNG_FRESH: rng_fresh_q <= cfg_data;
				mmc_pkg::CFG_RNG_REFINE: rng_refine_q <= cfg_data;
				mmc_pkg::CFG_SCALE_FLOOR: sc_floor_q <= cfg_data;
				mmc_pkg::CFG_BOUND_MARGIN: margin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Calibration state and per-word work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				off_q[i] <= '0;
				scale_q[i] <= SCW'(mmc_pkg::SCALE_ONE);
				vlo_q[i] <= BOUND_LO;
				vhi_q[i] <= BOUND_HI;
				fmin_q[i] <= BOUND_HI;
				fmax_q[i] <= BOUND_LO;
				bmin_q[i] <= BOUND_HI;
				bmax_q[i] <= BOUND_LO;
			end
			fg_active_q <= 1'b0;
			bg_started_q <= 1'b0;
			has_stored_q <= 1'b0;
			fg_cnt_q <= '0;
			bg_cnt_q <= '0;
			ax_q <= '0;
			src_bg_q <= 1'b0;
			sum_q <= '0;
		end else begin
			case (state_q)
				mmc_pkg::ST_START: begin
					fg_active_q <= 1'b1;
					fg_cnt_q <= '0;
					for (int i = 0; i < 3; i++) begin
						fmin_q[i] <= BOUND_HI;
						fmax_q[i] <= BOUND_LO;
					end
				end
				mmc_pkg::ST_FG_TRACK: begin
					for (int i = 0; i < 3; i++) begin
						if (MW'(s_q[i]) < fmin_q[i]) fmin_q[i] <= MW'(s_q[i]);
						if (MW'(s_q[i]) > fmax_q[i]) fmax_q[i] <= MW'(s_q[i]);
					end
					fg_cnt_q <= fg_cnt_inc;
				end
				mmc_pkg::ST_FG_SET: begin
					// Midpoints and widened bounds from the explicit extremes
					for (int i = 0; i < 3; i++) begin
						off_q[i] <= W'(((MW+1)'(fmax_q[i]) + (MW+1)'(fmin_q[i])) >>> 1);
						if (EW'(fmin_q[i]) - EW'($signed({1'b0, margin_q})) < E_LO)
							vlo_q[i] <= MW'(E_LO);
						else vlo_q[i] <= fmin_q[i] - MW'(margin_q);
						if (EW'(fmax_q[i]) + EW'($signed({1'b0, margin_q})) > E_HI)
							vhi_q[i] <= MW'(E_HI);
						else vhi_q[i] <= fmax_q[i] + MW'(margin_q);
					end
					fg_active_q <= 1'b0;
					src_bg_q <= 1'b0;
				end
				mmc_pkg::ST_SC_SUM: begin
					sum_q <= SW'(d0 > 0 ? d0[W-1:0] : '0) + SW'(d1 > 0 ? d1[W-1:0] : '0)
						+ SW'(d2 > 0 ? d2[W-1:0] : '0);
					ax_q <= '0;
				end
				mmc_pkg::ST_SC_AX: begin
					if (!d_gt && !last_ax) ax_q <= ax_q + 1'b1;
				end
				mmc_pkg::ST_SC_WAIT: begin
					if (div_done) begin
						scale_q[ax_q] <= q_sat;
						if (!last_ax) ax_q <= ax_q + 1'b1;
					end
				end
				mmc_pkg::ST_BG_TRACK: begin
					if (bg_due_q) begin
						if (!bg_started_q) begin
							has_stored_q <= (off_q[0] != '0) || (off_q[1] != '0);
							bg_started_q <= 1'b1;
						end
						for (int i = 0; i < 3; i++) begin
							if (MW'(s_q[i]) < bmin_q[i]) bmin_q[i] <= MW'(s_q[i]);
							if (MW'(s_q[i]) > bmax_q[i]) bmax_q[i] <= MW'(s_q[i]);
						end
						bg_cnt_q <= bg_cnt_inc;
					end
				end
				mmc_pkg::ST_BG_REF: begin
					// Average the new midpoint into the stored offset
					for (int i = 0; i < 3; i++) begin
						off_q[i] <= W'((((MW+3)'(off_q[i]) <<< 1) + (MW+3)'(bmax_q[i])
							+ (MW+3)'(bmin_q[i])) >>> 2);
					end
				end
				mmc_pkg::ST_BG_MID: begin
					for (int i = 0; i < 3; i++) begin
						off_q[i] <= W'(((MW+1)'(bmax_q[i]) + (MW+1)'(bmin_q[i])) >>> 1);
					end
					has_stored_q <= 1'b1;
					src_bg_q <= 1'b1;
				end
				mmc_pkg::ST_BG_END: begin
					bg_cnt_q <= '0;
					for (int i = 0; i < 3; i++) begin
						bmin_q[i] <= MW'(s_q[i]);
						bmax_q[i] <= MW'(s_q[i]);
					end
				end
				mmc_pkg::ST_COR: ax_q <= '0;
				mmc_pkg::ST_MUL_WAIT: begin
					if (mul_done && !last_ax) ax_q <= ax_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Word capture and result build
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= func;
			bg_due_q <= bg_due;
			s_q[0] <= mag_x;
			s_q[1] <= mag_y;
			s_q[2] <= mag_z;
			oor_q <= 1'b0;
			fin_q <= 1'b0;
			status_q <= mmc_pkg::BG_NONE;
		end
		case (state_q)
			mmc_pkg::ST_START: begin
				for (int i = 0; i < 3; i++) corr_q[i] <= '0;
				applied_q <= 1'b0;
			end
			mmc_pkg::ST_FG_SET: fin_q <= 1'b1;
			mmc_pkg::ST_BG_CHK: begin
				if (bg_ge) status_q <= rng_ok ? mmc_pkg::BG_UPDATED : mmc_pkg::BG_SHORT;
			end
			mmc_pkg::ST_COR: begin
				applied_q <= applied;
				for (int i = 0; i < 3; i++) corr_q[i] <= s_q[i];
			end
			mmc_pkg::ST_MUL_WAIT: begin
				if (mul_done) begin
					if (v < vlo_ext || v > vhi_ext) oor_q <= 1'b1;
					if (v > V_HI) corr_q[ax_q] <= W'(V_HI);
					else if (v < V_LO) corr_q[ax_q] <= W'(V_LO);
					else corr_q[ax_q] <= W'(v);
				end
			end
			default: ;
		endcase
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mmc_pkg::ST_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mmc_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
			ox_q <= corr_q[0];
			oy_q <= corr_q[1];
			oz_q <= corr_q[2];
			ocorr_q <= applied_q;
			ooor_q <= oor_q && !func_q;
			ocal_q <= fg_active_q;
			ofin_q <= fin_q && !func_q;
			ostat_q <= func_q ? mmc_pkg::BG_NONE : status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign corr_x = ox_q;
	assign corr_y = oy_q;
	assign corr_z = oz_q;
	assign corrected = ocorr_q;
	assign out_of_range = ooor_q;
	assign calibrating = ocal_q;
	assign fg_finished = ofin_q;
	assign bg_status = ostat_q;

endmodule

// ----- design/mmc_chk.sv -----
// Port checker for the calibrator core and its bind.
`timescale 1ns / 1ps
module mmc_chk #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] corr_x,
	input logic                    corrected,
	input logic                    out_of_range,
	input logic                    calibrating,
	input logic                    fg_finished
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(corr_x))
		else $error("result word changed while stalled");

	// Take one word at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// A finished calibration corrects its own word and leaves explicit mode
	a_fin_applies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fg_finished |-> corrected && !calibrating)
		else $error("finished calibration without correction");

	// Range flag only on corrected words
	a_oor_corr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> corrected)
		else $error("range flag on an uncorrected word");

endmodule

bind magnetometer_minmax_calibrator_core mmc_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mmc_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.corr_x(corr_x),
	.corrected(corrected),
	.out_of_range(out_of_range),
	.calibrating(calibrating),
	.fg_finished(fg_finished)
);
